// ----- sv/cdb_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package cdb_pkg;
  localparam int GRID_SIZE = 256;
  localparam int IDX_W = 8;
  localparam int HALF = GRID_SIZE / 2;
  localparam int DATA_W = 32;
  localparam int MAG_W = 16;
  localparam int AMAG_W = 8;
  localparam int SQ_W = 15;
  localparam int SUM_W = 16;
  localparam int RHS_W = 47;
  localparam int T_W = 53;
  localparam int U_W = 36;
  localparam int PROD_W = 48;
  localparam int PLEN_W = 16;
  localparam logic [PLEN_W-1:0] PLEN_RESET = 16'd256;
  localparam logic [DATA_W-1:0] DATA_MAX = 32'h7fff_ffff;
  localparam logic [DATA_W-1:0] DATA_MIN = 32'h8000_0000;

  typedef struct packed {
    logic [MAG_W-1:0] m;
    logic signed [T_W-1:0] t;
    logic signed [U_W-1:0] u;
  } dir_t;

  typedef struct packed {
    logic valid;
    logic zero;
    logic x_neg;
    logic z_neg;
    logic [SUM_W-1:0] s;
    logic [RHS_W-1:0] rhs_x;
    logic [RHS_W-1:0] rhs_z;
    logic signed [DATA_W-1:0] him;
    logic signed [DATA_W-1:0] nre;
  } pay_t;
endpackage
`default_nettype wire

// ----- sv/choppy_displacement_bin.sv -----
`timescale 1ns / 1ps
`default_nettype none
// channel   | signals                                        | handshake
// request   | col_index row_index height_re height_im        | start && !busy
// result    | disp_x_re disp_x_im disp_z_re disp_z_im        | done, one cycle
//           | bin_zeroed                                     |
// config    | cfg_data (patch_length)                        | cfg_valid && cfg_ready
// One request per cycle; busy stays low. The pipeline has one prep stage,
// 16 direction stages (one result bit each, per axis), multiply and round stages.
// rst is synchronous and clears the valid chain; patch_length returns to 256.
// The receiver cannot stall; the pipeline never holds.
module choppy_displacement_bin (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic start,
  output logic busy,
  input  wire logic [cdb_pkg::IDX_W-1:0] col_index,
  input  wire logic [cdb_pkg::IDX_W-1:0] row_index,
  input  wire logic signed [cdb_pkg::DATA_W-1:0] height_re,
  input  wire logic signed [cdb_pkg::DATA_W-1:0] height_im,
  output logic done,
  output logic signed [cdb_pkg::DATA_W-1:0] disp_x_re,
  output logic signed [cdb_pkg::DATA_W-1:0] disp_x_im,
  output logic signed [cdb_pkg::DATA_W-1:0] disp_z_re,
  output logic signed [cdb_pkg::DATA_W-1:0] disp_z_im,
  output logic bin_zeroed,
  input  wire logic cfg_valid,
  output logic cfg_ready,
  input  wire logic [cdb_pkg::PLEN_W-1:0] cfg_data
);
  import cdb_pkg::*;

  localparam int STEPS = MAG_W;

  pay_t pay [0:STEPS];
  dir_t dx [0:STEPS];
  dir_t dz [0:STEPS];
  logic [PLEN_W-1:0] patch_length;
  logic valid_a, zero_a;

  assign busy = 1'b0;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      patch_length <= PLEN_RESET;
    end else if (cfg_valid && cfg_ready) begin
      patch_length <= cfg_data;
    end
  end

  cdb_prep u_prep (
    .clk(clk), .rst(rst), .take(start && !busy),
    .col_index(col_index), .row_index(row_index),
    .height_re(height_re), .height_im(height_im),
    .pay(pay[0]), .dx(dx[0]), .dz(dz[0])
  );

  for (genvar k = 0; k < STEPS; k++) begin : g_step
    cdb_dir_step #(.BIT(STEPS - 1 - k)) u_x (
      .clk(clk), .d_in(dx[k]), .s(pay[k].s), .rhs(pay[k].rhs_x), .d_out(dx[k+1])
    );
    cdb_dir_step #(.BIT(STEPS - 1 - k)) u_z (
      .clk(clk), .d_in(dz[k]), .s(pay[k].s), .rhs(pay[k].rhs_z), .d_out(dz[k+1])
    );
    always_ff @(posedge clk) begin
      if (rst) begin
        pay[k+1].valid <= 1'b0;
      end else begin
        pay[k+1].valid <= pay[k].valid;
      end
      pay[k+1].zero <= pay[k].zero;
      pay[k+1].x_neg <= pay[k].x_neg;
      pay[k+1].z_neg <= pay[k].z_neg;
      pay[k+1].s <= pay[k].s;
      pay[k+1].rhs_x <= pay[k].rhs_x;
      pay[k+1].rhs_z <= pay[k].rhs_z;
      pay[k+1].him <= pay[k].him;
      pay[k+1].nre <= pay[k].nre;
    end
  end

  cdb_scale u_xre (
    .clk(clk), .umag(dx[STEPS].m), .uneg(pay[STEPS].x_neg), .zero(pay[STEPS].zero),
    .v(pay[STEPS].him), .res(disp_x_re)
  );
  cdb_scale u_xim (
    .clk(clk), .umag(dx[STEPS].m), .uneg(pay[STEPS].x_neg), .zero(pay[STEPS].zero),
    .v(pay[STEPS].nre), .res(disp_x_im)
  );
  cdb_scale u_zre (
    .clk(clk), .umag(dz[STEPS].m), .uneg(pay[STEPS].z_neg), .zero(pay[STEPS].zero),
    .v(pay[STEPS].him), .res(disp_z_re)
  );
  cdb_scale u_zim (
    .clk(clk), .umag(dz[STEPS].m), .uneg(pay[STEPS].z_neg), .zero(pay[STEPS].zero),
    .v(pay[STEPS].nre), .res(disp_z_im)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_a <= 1'b0;
      done <= 1'b0;
    end else begin
      valid_a <= pay[STEPS].valid;
      done <= valid_a;
    end
    zero_a <= pay[STEPS].zero;
    bin_zeroed <= zero_a;
  end
endmodule
`default_nettype wire

// ----- sv/cdb_prep.sv -----
`timescale 1ns / 1ps
`default_nettype none
module cdb_prep (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic take,
  input  wire logic [cdb_pkg::IDX_W-1:0] col_index,
  input  wire logic [cdb_pkg::IDX_W-1:0] row_index,
  input  wire logic signed [cdb_pkg::DATA_W-1:0] height_re,
  input  wire logic signed [cdb_pkg::DATA_W-1:0] height_im,
  output cdb_pkg::pay_t pay,
  output cdb_pkg::dir_t dx,
  output cdb_pkg::dir_t dz
);
  import cdb_pkg::*;

  localparam logic [IDX_W-1:0] HALF_I = IDX_W'(HALF);

  logic [AMAG_W-1:0] ai, aj;
  logic [SQ_W-1:0] ai2, aj2;
  logic [SUM_W-1:0] s;
  logic zero;
  logic signed [T_W-1:0] s_t;

  always_comb begin
    ai = (col_index < HALF_I) ? AMAG_W'(HALF_I - col_index) : AMAG_W'(col_index - HALF_I);
    aj = (row_index < HALF_I) ? AMAG_W'(HALF_I - row_index) : AMAG_W'(row_index - HALF_I);
    ai2 = SQ_W'(ai * ai);
    aj2 = SQ_W'(aj * aj);
    s = SUM_W'(ai2) + SUM_W'(aj2);
    zero = (col_index == '0) || (row_index == '0) ||
           ((col_index == HALF_I) && (row_index == HALF_I));
    s_t = $signed(T_W'(s));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pay.valid <= 1'b0;
    end else begin
      pay.valid <= take;
    end
    pay.zero <= zero;
    pay.x_neg <= col_index < HALF_I;
    pay.z_neg <= row_index < HALF_I;
    pay.s <= s;
    pay.rhs_x <= {RHS_W'(ai2)} << 32;
    pay.rhs_z <= {RHS_W'(aj2)} << 32;
    pay.him <= height_im;
    pay.nre <= (height_re == DATA_MIN) ? $signed(DATA_MAX) : -height_re;
    dx.m <= '0;
    dx.t <= s_t;
    dx.u <= -$signed(U_W'(s));
    dz.m <= '0;
    dz.t <= s_t;
    dz.u <= -$signed(U_W'(s));
  end
endmodule
`default_nettype wire

// ----- sv/cdb_dir_step.sv -----
`timescale 1ns / 1ps
`default_nettype none
module cdb_dir_step #(
  parameter int BIT = 0
) (
  input  wire logic clk,
  input  wire cdb_pkg::dir_t d_in,
  input  wire logic [cdb_pkg::SUM_W-1:0] s,
  input  wire logic [cdb_pkg::RHS_W-1:0] rhs,
  output cdb_pkg::dir_t d_out
);
  import cdb_pkg::*;

  logic signed [T_W-1:0] u_ext, s_ext, rhs_ext, cand;
  logic signed [U_W-1:0] u_add;
  logic hit;

  // t = 2m-1 tracked as t^2*s and t*s, so each trial is shifts and adds
  always_comb begin
    u_ext = T_W'(d_in.u);
    s_ext = $signed(T_W'(s));
    rhs_ext = $signed(T_W'(rhs));
    cand = d_in.t + (u_ext <<< (BIT + 2)) + (s_ext <<< (2 * BIT + 2));
    hit = cand <= rhs_ext;
    u_add = $signed(U_W'(s)) <<< (BIT + 1);
  end

  always_ff @(posedge clk) begin
    if (hit) begin
      d_out.m <= d_in.m | (MAG_W'(1) << BIT);
      d_out.t <= cand;
      d_out.u <= d_in.u + u_add;
    end else begin
      d_out <= d_in;
    end
  end
endmodule
`default_nettype wire

// ----- sv/cdb_scale.sv -----
`timescale 1ns / 1ps
`default_nettype none
module cdb_scale (
  input  wire logic clk,
  input  wire logic [cdb_pkg::MAG_W-1:0] umag,
  input  wire logic uneg,
  input  wire logic zero,
  input  wire logic signed [cdb_pkg::DATA_W-1:0] v,
  output logic signed [cdb_pkg::DATA_W-1:0] res
);
  import cdb_pkg::*;

  logic [DATA_W-1:0] vmag;
  logic [PROD_W-1:0] prod;
  logic sgn, zero_a;
  logic [DATA_W:0] r;
  logic neg;
  logic [DATA_W-1:0] res_next;

  always_comb begin
    vmag = v[DATA_W-1] ? (~DATA_W'(v) + DATA_W'(1)) : DATA_W'(v);
    r = (DATA_W + 1)'((prod + PROD_W'(16384)) >> 15);
    neg = sgn && (r != '0);
    if (zero_a) begin
      res_next = '0;
    end else if (neg) begin
      res_next = -r[DATA_W-1:0];
    end else if (r > (DATA_W + 1)'(DATA_MAX)) begin
      res_next = DATA_MAX;
    end else begin
      res_next = r[DATA_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    prod <= PROD_W'(umag) * PROD_W'(vmag);
    sgn <= uneg ^ v[DATA_W-1];
    zero_a <= zero;
    res <= $signed(res_next);
  end
endmodule
`default_nettype wire

// ----- sv/cdb_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none
module cdb_checker (
  input wire logic clk,
  input wire logic rst,
  input wire logic start,
  input wire logic busy,
  input wire logic done,
  input wire logic bin_zeroed,
  input wire logic [31:0] disp_x_re,
  input wire logic [31:0] disp_x_im,
  input wire logic [31:0] disp_z_re,
  input wire logic [31:0] disp_z_im
);
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##19 done) else $error("request result missing");
  a_no_ghost: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, 19)) else $error("result without request");
  a_zeroed: assert property (@(posedge clk) disable iff (rst)
    (done && bin_zeroed) |-> (disp_x_re == '0 && disp_x_im == '0 &&
    disp_z_re == '0 && disp_z_im == '0)) else $error("zeroed bin nonzero");
  a_busy: assert property (@(posedge clk) disable iff (rst)
    !busy) else $error("busy raised");
endmodule

bind choppy_displacement_bin cdb_checker u_cdb_checker (
  .clk(clk), .rst(rst), .start(start), .busy(busy), .done(done),
  .bin_zeroed(bin_zeroed), .disp_x_re(disp_x_re), .disp_x_im(disp_x_im),
  .disp_z_re(disp_z_re), .disp_z_im(disp_z_im)
);
`default_nettype wire

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 1ps
module tb_top;
  import cdb_pkg::*;

  logic clk = 0;
  logic rst = 1;
  logic start = 0;
  logic [IDX_W-1:0] col_index = '0;
  logic [IDX_W-1:0] row_index = '0;
  logic signed [DATA_W-1:0] height_re = '0;
  logic signed [DATA_W-1:0] height_im = '0;
  logic cfg_valid = 0;
  logic [PLEN_W-1:0] cfg_data = '0;
  logic busy, done, cfg_ready, bin_zeroed;
  logic signed [DATA_W-1:0] disp_x_re, disp_x_im, disp_z_re, disp_z_im;

  typedef struct packed {
    logic [DATA_W-1:0] xre, xim, zre, zim;
    logic zero;
  } disp_t;

  disp_t disp_q[$];
  logic [PLEN_W-1:0] plen_shadow;
  int errors = 0;
  int cycles = 0;
  localparam int LIMIT = 400000;
  localparam int LAT = 19;
  localparam logic [IDX_W-1:0] HALF_B = IDX_W'(HALF);

  choppy_displacement_bin u_top (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .col_index(col_index), .row_index(row_index),
    .height_re(height_re), .height_im(height_im),
    .done(done), .disp_x_re(disp_x_re), .disp_x_im(disp_x_im),
    .disp_z_re(disp_z_re), .disp_z_im(disp_z_im), .bin_zeroed(bin_zeroed),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  initial forever #2 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // floor(a*2^15/sqrt(s)+0.5) by exact compare
  function automatic logic [15:0] dir_mag(logic [63:0] a, logic [63:0] s);
    logic [31:0] lo, hi, mid;
    logic [63:0] rhs, t;
    lo = 0;
    hi = 32768;
    rhs = (a * a) << 32;
    while (lo < hi) begin
      mid = (lo + hi + 1) / 2;
      t = 2 * 64'(mid) - 1;
      if (t * t * s <= rhs) lo = mid;
      else hi = mid - 1;
    end
    return lo[15:0];
  endfunction

  function automatic logic [31:0] dir_scale(logic uneg, logic [15:0] umag,
                                             logic signed [31:0] v);
    logic vneg;
    logic [63:0] vmag, r;
    vneg = v < 0;
    vmag = vneg ? 64'(-64'(v)) : 64'(v);
    r = (64'(umag) * vmag + 16384) >> 15;
    if (uneg != vneg && r != 0) return 32'(64'h1_0000_0000 - r);
    if (r > 64'h7fff_ffff) r = 64'h7fff_ffff;
    return r[31:0];
  endfunction

  function automatic disp_t predict_disp(logic [7:0] i, logic [7:0] j,
                                         logic signed [31:0] hre,
                                         logic signed [31:0] him);
    disp_t d;
    int ic, jc;
    logic [63:0] ai, aj, s;
    logic [15:0] mx, mz;
    logic signed [31:0] nre;
    d = '0;
    ic = int'(i) - HALF;
    jc = int'(j) - HALF;
    if (i == 0 || j == 0 || (ic == 0 && jc == 0)) begin
      d.zero = 1;
      return d;
    end
    ai = 64'(ic < 0 ? -ic : ic);
    aj = 64'(jc < 0 ? -jc : jc);
    s = ai * ai + aj * aj;
    mx = dir_mag(ai, s);
    mz = dir_mag(aj, s);
    nre = (hre == $signed(DATA_MIN)) ? $signed(DATA_MAX) : -hre;
    d.xre = dir_scale(ic < 0, mx, him);
    d.xim = dir_scale(ic < 0, mx, nre);
    d.zre = dir_scale(jc < 0, mz, him);
    d.zim = dir_scale(jc < 0, mz, nre);
    return d;
  endfunction

  always @(posedge clk) begin
    disp_t e;
    if (!rst && done) begin
      if (disp_q.size() == 0) begin
        $display("%0t: unexpected result", $time);
        errors++;
      end else begin
        e = disp_q.pop_front();
        if (e.xre !== disp_x_re) begin
          $display("%0t: disp_x_re exp %h got %h", $time, e.xre, disp_x_re); errors++;
        end
        if (e.xim !== disp_x_im) begin
          $display("%0t: disp_x_im exp %h got %h", $time, e.xim, disp_x_im); errors++;
        end
        if (e.zre !== disp_z_re) begin
          $display("%0t: disp_z_re exp %h got %h", $time, e.zre, disp_z_re); errors++;
        end
        if (e.zim !== disp_z_im) begin
          $display("%0t: disp_z_im exp %h got %h", $time, e.zim, disp_z_im); errors++;
        end
        if (e.zero !== bin_zeroed) begin
          $display("%0t: bin_zeroed exp %b got %b", $time, e.zero, bin_zeroed); errors++;
        end
      end
    end
  end

  // start stays high between back-to-back requests; drain lowers it
  task automatic send_bin(logic [7:0] i, logic [7:0] j, logic [31:0] hre,
                          logic [31:0] him, bit gaps);
    int w;
    w = gaps ? $urandom_range(0, 10) : 0;
    if (w > 0) begin
      start <= 0;
      repeat (w) @(negedge clk);
    end
    start <= 1;
    col_index <= i;
    row_index <= j;
    height_re <= hre;
    height_im <= him;
    @(posedge clk);
    while (busy) @(posedge clk);
    disp_q.push_back(predict_disp(i, j, hre, him));
    @(negedge clk);
  endtask

  task automatic drain;
    start <= 0;
    while (disp_q.size() != 0) @(posedge clk);
    repeat (LAT + 5) @(negedge clk);
  endtask

  task automatic write_plen(logic [PLEN_W-1:0] v);
    drain();
    cfg_valid <= 1;
    cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    plen_shadow = v;
    @(negedge clk);
    cfg_valid <= 0;
  endtask

  task automatic test_directed;
    logic [31:0] ext[5];
    ext = '{32'h8000_0000, 32'h7fff_ffff, 32'h0, 32'hffff_ffff, 32'h0001_0000};
    send_bin(0, 10, 32'h1234, 32'h5678, 0);
    send_bin(10, 0, 32'h1234, 32'h5678, 0);
    send_bin(0, 0, 32'hffff_ffff, 32'h7fff_ffff, 0);
    send_bin(HALF_B, HALF_B, 32'h8000_0000, 32'h8000_0000, 0);
    send_bin(HALF_B, 255, 32'h8000_0000, 32'h7fff_ffff, 0);
    send_bin(255, HALF_B, 32'h7fff_ffff, 32'h8000_0000, 0);
    send_bin(1, 1, 32'h8000_0000, 32'h8000_0000, 0);
    send_bin(255, 255, 32'h7fff_ffff, 32'h7fff_ffff, 0);
    send_bin(1, 255, 32'hdead_beef, 32'h1357_9bdf, 0);
    send_bin(HALF_B + 8'd1, HALF_B, 32'h0001_0000, 32'hffff_0000, 0);
    send_bin(HALF_B, HALF_B - 8'd1, 32'h0001_0000, 32'hffff_0000, 0);
    for (int k = 0; k < 5; k++)
      send_bin(HALF_B + 8'd3, HALF_B - 8'd4, ext[k], ext[4 - k], 0);
    drain();
  endtask

  task automatic test_config;
    write_plen(16'd1);
    send_bin(200, 30, 32'h4000_0000, 32'hc000_0000, 0);
    write_plen(16'hffff);
    send_bin(200, 30, 32'h4000_0000, 32'hc000_0000, 0);
    write_plen(16'h5a5a);
    drain();
  endtask

  task automatic test_random(int n);
    logic [7:0] i, j;
    for (int k = 0; k < n; k++) begin
      i = 8'($urandom);
      j = 8'($urandom);
      if ($urandom_range(0, 15) == 0) i = 0;
      if ($urandom_range(0, 15) == 0) j = HALF_B;
      send_bin(i, j, $urandom, $urandom, (k / 100) % 2 == 0);
      if (k == n / 2) begin
        drain();
        write_plen(16'($urandom_range(1, 65535)));
      end
    end
  endtask

  initial begin
    plen_shadow = PLEN_RESET;
    repeat (7) @(negedge clk);
    rst <= 0;
    write_plen(PLEN_RESET);
    test_directed();
    test_config();
    test_random(1550);
    drain();
    if (errors == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end
endmodule
